// ===== src/utf8_codepoint_decoder_assert.svh =====
// Assertion macros used by the checker file of the UTF-8 decoder.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8CD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8cd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8CD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8cd: next-cycle check failed");

`endif

// ===== src/utf8cd_pkg.sv =====
// Package with the types and constants of the UTF-8 code point decoder.
`default_nettype none
package utf8cd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POINT_W = 16;
    localparam int OWED_W  = 2;
    localparam int PART_W  = 10;
    localparam int CONT_W  = 6;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

    localparam logic [OWED_W-1:0] OWED_NONE = 2'd0;
    localparam logic [OWED_W-1:0] OWED_ONE  = 2'd1;
    localparam logic [OWED_W-1:0] OWED_TWO  = 2'd2;

    typedef struct packed {
        logic [OWED_W-1:0] bytes_owed;
        logic [PART_W-1:0] partial_point;
    } state_t;

    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               point_valid;
        logic               end_seen;
    } result_t;

endpackage
`default_nettype wire

// ===== src/utf8_codepoint_decoder.sv =====
// Top level of the UTF-8 code point decoder: input register, decode, result register.
//
//   channel | direction | ports                                        | word
//   s_      | in        | s_valid s_ready s_byte_value s_text_end      | one text byte
//   m_      | out       | m_valid m_ready m_code_point m_point_valid   | one result
//           |           | m_end_seen                                   |
//
// Each byte gives one result word: it passes the input register, the decode, then the result register.
// One byte per cycle is sustained while m_ready stays high; a stalled result holds the flow.
// Synchronous active-low reset empties both registers and clears the sequence state.
// A stalled result holds, and the input register still takes a byte while it is empty.
`default_nettype none
module utf8_codepoint_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        s_text_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_point,
    output logic             m_point_valid,
    output logic             m_end_seen
);
    import utf8cd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;
    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    result_t           out_result_reg;
    result_t           result_next;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    utf8cd_decode u_decode (
        .byte_value (in_byte_reg),
        .text_end   (in_end_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_end_reg  <= s_text_end;
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_code_point  = out_result_reg.code_point;
    assign m_point_valid = out_result_reg.point_valid;
    assign m_end_seen    = out_result_reg.end_seen;

endmodule
`default_nettype wire

// ===== src/utf8cd_decode.sv =====
// Combinational decode of one byte against the current sequence state.
`default_nettype none
module utf8cd_decode (
    input  wire logic [7:0]         byte_value,
    input  wire logic               text_end,
    input  wire utf8cd_pkg::state_t state_cur,
    output utf8cd_pkg::state_t      state_next,
    output utf8cd_pkg::result_t     result
);
    import utf8cd_pkg::*;

    logic [POINT_W-1:0] acc;
    logic [OWED_W-1:0]  owed_dec;
    state_t             state_body;

    assign acc      = {state_cur.partial_point, byte_value[CONT_W-1:0] & CONT_BITS[CONT_W-1:0]};
    assign owed_dec = state_cur.bytes_owed - OWED_ONE;

    always_comb begin
        state_body         = state_cur;
        result.code_point  = '0;
        result.point_valid = 1'b0;
        result.end_seen    = text_end;
        if (state_cur.bytes_owed != OWED_NONE) begin
            state_body.bytes_owed = owed_dec;
            if (owed_dec == OWED_NONE) begin
                result.code_point       = acc;
                result.point_valid      = 1'b1;
                state_body.partial_point = '0;
            end else begin
                state_body.partial_point = acc[PART_W-1:0];
            end
        end else if (byte_value < ASCII_LIMIT) begin
            result.code_point  = {{(POINT_W-BYTE_W){1'b0}}, byte_value};
            result.point_valid = 1'b1;
        end else if ((byte_value & LEAD2_MASK) == LEAD2_CODE) begin
            state_body.partial_point = {{(PART_W-BYTE_W){1'b0}}, byte_value & LEAD2_BITS};
            state_body.bytes_owed    = OWED_ONE;
        end else if ((byte_value & LEAD3_MASK) == LEAD3_CODE) begin
            state_body.partial_point = {{(PART_W-BYTE_W){1'b0}}, byte_value & LEAD3_BITS};
            state_body.bytes_owed    = OWED_TWO;
        end
    end

    always_comb begin
        state_next = state_body;
        if (text_end) begin
            state_next = '0;
        end
    end

endmodule
`default_nettype wire

// ===== src/utf8cd_checker.sv =====
// Port-level checker for the UTF-8 code point decoder and its bind statement.
`default_nettype none
`include "utf8_codepoint_decoder_assert.svh"
module utf8cd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_code_point,
    input wire logic        m_point_valid,
    input wire logic        m_end_seen
);
    logic        m_stall;
    logic        s_stall;
    logic        cp_zero;
    logic [17:0] m_word;

    assign m_stall = m_valid && !m_ready;
    assign s_stall = s_valid && !s_ready;
    assign cp_zero = (m_code_point == 16'h0000);
    assign m_word  = {m_code_point, m_point_valid, m_end_seen};

    // A stalled result word keeps its contents.
    `UTF8CD_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_stall, m_valid && $stable(m_word))

    // A word that completes no code point carries a zero code point.
    `UTF8CD_ASSERT_SAME(a_zero_when_invalid, aclk, aresetn, m_valid && !m_point_valid, cp_zero)

    // Reset leaves no result word pending.
    `UTF8CD_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

    // With the input register full and the result slot stalled, no byte is taken while the stall lasts.
    `UTF8CD_ASSERT_NEXT(a_no_overrun, aclk, aresetn, s_stall && m_stall, !s_ready || !m_stall)

endmodule

bind utf8_codepoint_decoder utf8cd_checker u_checker (.*);
`default_nettype wire
